### design/rgrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative gradient refine tagger - shared package
// Sizes, payload types, register indexes and the structs passed between the
// sequencer, the tap store and the judge.
// ----------------------------------------------------------------------------
package rgrt_pkg;

	// Block limits
	localparam int MAX_X = 64;
	localparam int MAX_Y = 64;
	localparam int MAX_Z = 64;

	// Field widths
	localparam int SAMPLE_W  = 32;
	localparam int THR_W     = 24;
	localparam int SIZE_W    = 7;
	localparam int POS_W     = 6;
	localparam int CFG_IDX_W = 3;

	// Storage: two planes of history, two rows of history
	localparam int RING_DEPTH = 2 * MAX_X * MAX_Y;
	localparam int RING_AW    = $clog2(RING_DEPTH);
	localparam int LINE_DEPTH = 2 * MAX_X;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int PLANE_W    = 2 * SIZE_W;

	// Arithmetic: 0.5*|diff| > T/65536 * (|q|+1) becomes |diff| << 15 > T*(|q|+1)
	localparam int MAG_W      = SAMPLE_W;
	localparam int SCALE_W    = SAMPLE_W;
	localparam int PROD_W     = THR_W + SCALE_W;
	localparam int FRAC_SHIFT = 15;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REFINE_THR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEREFINE_THR = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_X       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z       = 3'd4;

	// Register reset values
	localparam logic [THR_W-1:0]  REFINE_THR_RST   = 24'd32768;
	localparam logic [THR_W-1:0]  DEREFINE_THR_RST = 24'd3277;
	localparam logic [SIZE_W-1:0] SIZE_RST         = 7'd64;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [THR_W-1:0]           thr_t;
	typedef logic [SIZE_W-1:0]          size_t;
	typedef logic [POS_W-1:0]           pos_t;
	typedef logic [RING_AW-1:0]         ring_addr_t;
	typedef logic [LINE_AW-1:0]         line_addr_t;
	typedef logic [MAG_W-1:0]           mag_t;
	typedef logic [SCALE_W-1:0]         scale_t;
	typedef logic [PROD_W-1:0]          prod_t;

	typedef enum logic [1:0] {
		DEC_DEREFINE = 2'd0,
		DEC_KEEP     = 2'd1,
		DEC_REFINE   = 2'd2
	} decision_t;

	// Per-cell control, fixed when the cell is taken
	typedef struct packed {
		logic eval;   // stencil centre is interior
		logic use_y;
		logic use_z;
		logic last;   // last cell of the block
	} item_t;

	// Tap distances, set by the block sizes
	typedef struct packed {
		ring_addr_t ring_lag_u;  // plane store lag of the upper y neighbour
		logic       u_direct;    // that lag is zero: take the incoming cell
		ring_addr_t ring_lag_z;  // plane store lag of the lower z neighbour
		line_addr_t line_lag_x;  // row store lag of the upper x neighbour
		logic       x_direct;    // that lag is zero: take the row store input
		line_addr_t line_lag_y;  // row store lag of the lower y neighbour
	} tap_ctl_t;

	// Neighbours of one centre cell plus its |q|+1
	typedef struct packed {
		sample_t x_hi;
		sample_t x_lo;
		sample_t y_hi;
		sample_t y_lo;
		sample_t z_hi;
		sample_t z_lo;
		scale_t  scale;
	} stencil_t;

	// Outcome of one cell's tests
	typedef struct packed {
		logic valid;
		logic above;      // some difference exceeds the refine threshold
		logic not_below;  // some difference is not below the derefine threshold
		logic last;
	} verdict_t;

endpackage

### design/rgrt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative gradient refine tagger - channel interfaces
// Valid/ready channels for cell words in and decision words out.
// ----------------------------------------------------------------------------
interface rgrt_cell_if import rgrt_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface rgrt_decision_if import rgrt_pkg::*; ();
	logic      valid;
	logic      ready;
	decision_t decision;

	modport source (output valid, output decision, input ready);
	modport sink   (input valid, input decision, output ready);
endinterface

### design/rgrt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative gradient refine tagger - raster sequencer
// Tracks the cell position, flags interior centres and the last cell, and
// derives the tap distances from the block sizes.
// ----------------------------------------------------------------------------
module rgrt_seq import rgrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  size_t    nx,
	input  size_t    ny,
	input  size_t    nz,
	input  logic     advance,
	input  logic     restart,
	output item_t    item,
	output tap_ctl_t taps
);

	pos_t pos_x_q, pos_y_q, pos_z_q;

	logic has_y, has_z, shift_x, shift_y;
	size_t px, py, pz;
	size_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
	logic ok_x, ok_y, ok_z;
	logic end_x, end_y, end_z;
	logic [PLANE_W-1:0] plane, span;

	assign has_y   = ny != size_t'(1);
	assign has_z   = nz != size_t'(1);
	// The axis whose far neighbour arrives last is the one the centre lags on
	assign shift_x = !has_y && !has_z;
	assign shift_y = has_y && !has_z;

	assign px = size_t'(pos_x_q);
	assign py = size_t'(pos_y_q);
	assign pz = size_t'(pos_z_q);

	always_comb begin
		lo_x = shift_x ? size_t'(2) : size_t'(1);
		hi_x = shift_x ? nx - size_t'(1) : nx - size_t'(2);
		lo_y = shift_y ? size_t'(2) : size_t'(1);
		hi_y = shift_y ? ny - size_t'(1) : ny - size_t'(2);
		lo_z = has_z ? size_t'(2) : size_t'(1);
		hi_z = has_z ? nz - size_t'(1) : nz - size_t'(2);
		ok_x = px >= lo_x && px <= hi_x;
		ok_y = !has_y || (py >= lo_y && py <= hi_y);
		ok_z = !has_z || (pz >= lo_z && pz <= hi_z);
	end

	assign end_x = px + size_t'(1) == nx;
	assign end_y = py + size_t'(1) == ny;
	assign end_z = pz + size_t'(1) == nz;

	assign item.eval  = ok_x && ok_y && ok_z;
	assign item.use_y = has_y;
	assign item.use_z = has_z;
	assign item.last  = end_x && end_y && end_z;

	assign plane = PLANE_W'(nx) * PLANE_W'(ny);
	assign span  = plane - PLANE_W'(nx);

	always_comb begin
		taps.u_direct   = !has_z;
		taps.ring_lag_u = '0;
		if (has_z) begin
			taps.ring_lag_u = has_y ? span[RING_AW-1:0] : RING_AW'(nx - size_t'(1));
		end
		taps.ring_lag_z = {plane[RING_AW-2:0], 1'b0};
		taps.x_direct   = !has_y;
		taps.line_lag_x = LINE_AW'(nx - size_t'(1));
		taps.line_lag_y = LINE_AW'({nx, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (restart) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
		end else if (advance) begin
			if (item.last || end_x) begin
				pos_x_q <= '0;
			end else begin
				pos_x_q <= pos_x_q + 1'b1;
			end
			if (item.last || (end_x && end_y)) begin
				pos_y_q <= '0;
			end else if (end_x) begin
				pos_y_q <= pos_y_q + 1'b1;
			end
			if (item.last) begin
				pos_z_q <= '0;
			end else if (end_x && end_y) begin
				pos_z_q <= pos_z_q + 1'b1;
			end
		end
	end

endmodule

### design/rgrt_taps.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative gradient refine tagger - neighbour store
// A plane store delays the stream by up to two planes; a row store behind it
// delays by up to two rows. Three registers give the x neighbours.
// ----------------------------------------------------------------------------
module rgrt_taps import rgrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     advance,
	input  sample_t  sample,
	input  item_t    item,
	input  tap_ctl_t ctl,
	output logic     valid_s2,
	output item_t    item_s2,
	output stencil_t stencil
);

	function automatic scale_t mag_plus_one(sample_t v);
		return v[SAMPLE_W-1] ? (~scale_t'(v) + scale_t'(2)) : (scale_t'(v) + scale_t'(1));
	endfunction

	sample_t ring_mem [RING_DEPTH];
	sample_t line_mem [LINE_DEPTH];

	ring_addr_t ring_wp_q, ring_ra_u, ring_ra_z;
	line_addr_t line_wp_q, line_ra_x, line_ra_y;

	logic       valid_s1;
	item_t      item_s1;
	sample_t    cur_s1, u_s1, zlo_s1;
	line_addr_t lag_x_s1, lag_y_s1;
	logic       x_direct_s1;

	sample_t x_hi_s2, x_mid_s2, x_lo_s2, y_hi_s2, y_lo_s2, z_hi_s2, z_lo_s2;
	scale_t  scale_s2;

	// Ring pointers wrap on their own: both depths are powers of two
	assign ring_ra_u = ring_wp_q - ctl.ring_lag_u;
	assign ring_ra_z = ring_wp_q - ctl.ring_lag_z;
	assign line_ra_x = line_wp_q - lag_x_s1;
	assign line_ra_y = line_wp_q - lag_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_wp_q <= '0;
			line_wp_q <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
		end else begin
			valid_s1 <= advance;
			valid_s2 <= valid_s1;
			if (advance) begin
				ring_wp_q <= ring_wp_q + 1'b1;
			end
			if (valid_s1) begin
				line_wp_q <= line_wp_q + 1'b1;
			end
		end
	end

	// Plane store: read before write, so a full-depth lag returns the oldest word
	always_ff @(posedge clk) begin
		if (advance) begin
			ring_mem[ring_wp_q] <= sample;
			u_s1        <= ctl.u_direct ? sample : ring_mem[ring_ra_u];
			zlo_s1      <= ring_mem[ring_ra_z];
			cur_s1      <= sample;
			item_s1     <= item;
			lag_x_s1    <= ctl.line_lag_x;
			lag_y_s1    <= ctl.line_lag_y;
			x_direct_s1 <= ctl.x_direct;
		end
	end

	// Row store fed by the upper y neighbour stream
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[line_wp_q] <= u_s1;
			x_hi_s2  <= x_direct_s1 ? u_s1 : line_mem[line_ra_x];
			x_mid_s2 <= x_hi_s2;
			x_lo_s2  <= x_mid_s2;
			scale_s2 <= mag_plus_one(x_hi_s2);
			y_hi_s2  <= u_s1;
			y_lo_s2  <= line_mem[line_ra_y];
			z_hi_s2  <= cur_s1;
			z_lo_s2  <= zlo_s1;
			item_s2  <= item_s1;
		end
	end

	assign stencil.x_hi  = x_hi_s2;
	assign stencil.x_lo  = x_lo_s2;
	assign stencil.y_hi  = y_hi_s2;
	assign stencil.y_lo  = y_lo_s2;
	assign stencil.z_hi  = z_hi_s2;
	assign stencil.z_lo  = z_lo_s2;
	assign stencil.scale = scale_s2;

endmodule

### design/rgrt_judge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative gradient refine tagger - threshold judge
// Forms |diff| on each axis and T*(|q|+1) for both thresholds, registers
// them, then compares by cross-multiplication.
// ----------------------------------------------------------------------------
module rgrt_judge import rgrt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     valid_s2,
	input  item_t    item_s2,
	input  stencil_t stencil,
	input  thr_t     refine_thr,
	input  thr_t     derefine_thr,
	output verdict_t verdict
);

	function automatic mag_t abs_diff(sample_t a, sample_t b);
		logic [SAMPLE_W:0] d_ab;
		logic [SAMPLE_W:0] d_ba;
		d_ab = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
		d_ba = {b[SAMPLE_W-1], b} - {a[SAMPLE_W-1], a};
		return d_ab[SAMPLE_W] ? d_ba[MAG_W-1:0] : d_ab[MAG_W-1:0];
	endfunction

	function automatic prod_t lhs(mag_t m);
		return PROD_W'({m, {FRAC_SHIFT{1'b0}}});
	endfunction

	logic  valid_s3;
	item_t item_s3;
	mag_t  mag_x_s3, mag_y_s3, mag_z_s3;
	prod_t prod_r_s3, prod_d_s3;

	logic ax, ay, az, nx_hit, ny_hit, nz_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			item_s3   <= item_s2;
			mag_x_s3  <= abs_diff(stencil.x_hi, stencil.x_lo);
			mag_y_s3  <= abs_diff(stencil.y_hi, stencil.y_lo);
			mag_z_s3  <= abs_diff(stencil.z_hi, stencil.z_lo);
			prod_r_s3 <= PROD_W'(refine_thr) * PROD_W'(stencil.scale);
			prod_d_s3 <= PROD_W'(derefine_thr) * PROD_W'(stencil.scale);
		end
	end

	assign ax     = lhs(mag_x_s3) > prod_r_s3;
	assign ay     = lhs(mag_y_s3) > prod_r_s3;
	assign az     = lhs(mag_z_s3) > prod_r_s3;
	assign nx_hit = lhs(mag_x_s3) >= prod_d_s3;
	assign ny_hit = lhs(mag_y_s3) >= prod_d_s3;
	assign nz_hit = lhs(mag_z_s3) >= prod_d_s3;

	assign verdict.valid     = valid_s3;
	assign verdict.last      = item_s3.last;
	assign verdict.above     = item_s3.eval &&
		(ax || (item_s3.use_y && ay) || (item_s3.use_z && az));
	assign verdict.not_below = item_s3.eval &&
		(nx_hit || (item_s3.use_y && ny_hit) || (item_s3.use_z && nz_hit));

endmodule

### design/relative_gradient_refine_tagger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative gradient refine tagger - top level
// Streams the cells of one 3D block and tags the block for refinement,
// derefinement or no change from its largest relative first derivative.
// ----------------------------------------------------------------------------
// One cell word is taken every clock, back to back, and a block's last cell passes
// the tap and judge stages before its decision word leaves. Cells arrive in
// raster order, x fastest; sizes count one ghost cell on each side of every
// direction that is present. Each cell passes a plane store (8192 words, one
// write and two reads per cell), a row store (128 words, one write and two
// reads) and a 24x32 multiply pair, one register stage each, so the rate is
// set by the single write port of the plane store. The input holds off only
// when a block's last cell arrives while the previous block's decision is
// still unread or still in flight; every other cell is taken even while a
// decision waits. Neither store needs clearing: a block reads only what it
// wrote itself. Any write to a listed register restarts the block; registers
// must be written only while no cell is in flight.
// ----------------------------------------------------------------------------
module relative_gradient_refine_tagger_unit import rgrt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [THR_W-1:0]     cfg_data,
	rgrt_cell_if.sink            cells,
	rgrt_decision_if.source      result
);

	function automatic size_t clamp_size(size_t v, size_t lo, size_t hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Configuration; sizes are held already clamped
	thr_t  refine_thr_q, derefine_thr_q;
	size_t nx_q, ny_q, nz_q;
	logic  cfg_hit;

	// Stream control
	item_t     cell_item;
	tap_ctl_t  tap_ctl;
	logic      accept, ready;
	logic      valid_s2;
	item_t     item_s2;
	stencil_t  stencil;
	verdict_t  verdict;

	// Block flags and decision word
	logic      any_q, all_q, last_pending_q, out_valid_q;
	logic      any_n, all_n;
	decision_t decision_q, dec_n;

	assign cfg_hit = cfg_write && cfg_index <= REG_SIZE_Z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refine_thr_q   <= REFINE_THR_RST;
			derefine_thr_q <= DEREFINE_THR_RST;
			nx_q           <= SIZE_RST;
			ny_q           <= SIZE_RST;
			nz_q           <= SIZE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_REFINE_THR: begin
					refine_thr_q <= cfg_data;
				end
				REG_DEREFINE_THR: begin
					derefine_thr_q <= cfg_data;
				end
				REG_SIZE_X: begin
					nx_q <= clamp_size(cfg_data[SIZE_W-1:0], size_t'(2), size_t'(MAX_X));
				end
				REG_SIZE_Y: begin
					ny_q <= clamp_size(cfg_data[SIZE_W-1:0], size_t'(1), size_t'(MAX_Y));
				end
				REG_SIZE_Z: begin
					nz_q <= clamp_size(cfg_data[SIZE_W-1:0], size_t'(1), size_t'(MAX_Z));
				end
				default: begin
					// unlisted index: drop the write
				end
			endcase
		end
	end

	// Hold off a last cell until the decision slot is free and no other last
	// cell is still in the pipe
	assign ready       = !(cell_item.last && (out_valid_q || last_pending_q));
	assign cells.ready = ready;
	assign accept      = cells.valid && ready;

	rgrt_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.nx      (nx_q),
		.ny      (ny_q),
		.nz      (nz_q),
		.advance (accept),
		.restart (cfg_hit),
		.item    (cell_item),
		.taps    (tap_ctl)
	);

	rgrt_taps u_taps (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (accept),
		.sample   (cells.sample),
		.item     (cell_item),
		.ctl      (tap_ctl),
		.valid_s2 (valid_s2),
		.item_s2  (item_s2),
		.stencil  (stencil)
	);

	rgrt_judge u_judge (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s2     (valid_s2),
		.item_s2      (item_s2),
		.stencil      (stencil),
		.refine_thr   (refine_thr_q),
		.derefine_thr (derefine_thr_q),
		.verdict      (verdict)
	);

	// Fold this cell into the block flags; refine wins over derefine, and a
	// zero derefine threshold never derefines
	always_comb begin
		any_n = any_q || verdict.above;
		all_n = all_q && !verdict.not_below;
		if (any_n) begin
			dec_n = DEC_REFINE;
		end else if (all_n && derefine_thr_q != '0) begin
			dec_n = DEC_DEREFINE;
		end else begin
			dec_n = DEC_KEEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q          <= 1'b0;
			all_q          <= 1'b1;
			last_pending_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_hit) begin
				any_q <= 1'b0;
				all_q <= 1'b1;
			end else if (verdict.valid) begin
				// restart the flags after the last cell, advance them otherwise
				any_q <= verdict.last ? 1'b0 : any_n;
				all_q <= verdict.last ? 1'b1 : all_n;
			end
			if (accept && cell_item.last) begin
				last_pending_q <= 1'b1;
			end else if (verdict.valid && verdict.last) begin
				last_pending_q <= 1'b0;
			end
			if (verdict.valid && verdict.last) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (verdict.valid && verdict.last) begin
			decision_q <= dec_n;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.decision = decision_q;

	// A decision never waits while another last cell is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid_q && last_pending_q))
		else $error("decision slot full with a last cell in flight");

	// A taken last cell always yields its decision word
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cell_item.last) |-> ##4 out_valid_q)
		else $error("decision missing after last cell");

	// A decision word appears only from a last-cell verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(verdict.valid && verdict.last))
		else $error("decision raised without a last cell");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relative gradient refine tagger - testbench
// Streams 3D blocks of cell words into the tagger with random gaps and
// stalls. A local predictor mirrors the tagger's history buffer, stencil tests
// and decision rule, and queues the expected decision word of every block.
// Each decision leaving the tagger is checked against the oldest queued one.
// ----------------------------------------------------------------------------
module tb;
	import rgrt_pkg::*;

	localparam int CLK_HALF         = 2;
	localparam int RESET_CYCLES     = 11;
	localparam int DECISION_LATENCY = 4;
	// Quiet time before a register write, so a block that produced no decision
	// has left the pipeline too
	localparam int SETTLE_CYCLES    = 3 * DECISION_LATENCY;
	localparam int STALL_LIMIT      = 2000;
	localparam int REPORT_LIMIT     = 10;
	localparam int RANDOM_WORDS     = 60;
	localparam int RANDOM_DECISIONS = 4;

	// Indexes past the register list: writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	localparam thr_t    THR_MAX    = '1;
	localparam sample_t SAMPLE_MIN = 32'h8000_0000;
	localparam sample_t SAMPLE_MAX = 32'h7FFF_FFFF;
	localparam sample_t SAMPLE_ONE = 32'h0001_0000;
	// 0.1 relative gradient around 1.0: between the reset thresholds
	localparam int      KEEP_STEP  = 6554;

	typedef enum int {
		FIELD_NOISE,
		FIELD_FLAT,
		FIELD_SMOOTH,
		FIELD_RAMP,
		FIELD_SMALL
	} field_kind_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	thr_t                 cfg_data;

	rgrt_cell_if     cells_ch();
	rgrt_decision_if result_ch();

	relative_gradient_refine_tagger_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cells     (cells_ch),
		.result    (result_ch)
	);

	// ------------------------------------------------------------------------
	// Predictor state: history of past words, raster position, the two
	// running flags of the block and a copy of every register
	// ------------------------------------------------------------------------
	sample_t     plane_hist [RING_DEPTH];
	int unsigned at_x, at_y, at_z, hist_ptr;
	bit          any_above, all_below;
	thr_t        refine_thr, derefine_thr;
	size_t       size_x_reg, size_y_reg, size_z_reg;

	decision_t   decisions_due [$];
	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned decisions_seen;
	bit          idle_on;

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic int unsigned clamp_size(size_t v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return 32'(v);
	endfunction

	function automatic void restart_block();
		at_x      = 0;
		at_y      = 0;
		at_z      = 0;
		hist_ptr  = 0;
		any_above = 1'b0;
		all_below = 1'b1;
	endfunction

	function automatic void reset_model();
		foreach (plane_hist[i]) plane_hist[i] = '0;
		refine_thr   = REFINE_THR_RST;
		derefine_thr = DEREFINE_THR_RST;
		size_x_reg   = SIZE_RST;
		size_y_reg   = SIZE_RST;
		size_z_reg   = SIZE_RST;
		restart_block();
	endfunction

	// Any listed register restarts the block; spare indexes are dropped
	function automatic void model_reg_write(logic [CFG_IDX_W-1:0] idx, thr_t data);
		case (idx)
			REG_REFINE_THR:   refine_thr   = data;
			REG_DEREFINE_THR: derefine_thr = data;
			REG_SIZE_X:       size_x_reg   = data[SIZE_W-1:0];
			REG_SIZE_Y:       size_y_reg   = data[SIZE_W-1:0];
			REG_SIZE_Z:       size_z_reg   = data[SIZE_W-1:0];
			default:          return;
		endcase
		restart_block();
	endfunction

	// Word that arrived lag words ago; lag 0 is the word being taken now
	function automatic longint hist_back(int unsigned lag, sample_t word_in);
		int unsigned idx;
		if (lag == 0) return word_in;
		idx = (hist_ptr >= lag) ? hist_ptr - lag : hist_ptr + RING_DEPTH - lag;
		return plane_hist[idx];
	endfunction

	// 0.5*|diff| against T/65536 * (|q|+1), compared exactly on integers
	function automatic void test_pair(longint hi, longint lo, longint unsigned scale);
		longint          diff;
		longint unsigned mag, lhs;
		diff = hi - lo;
		mag  = (diff < 0) ? -diff : diff;
		lhs  = mag * 64'd32768;
		if (lhs > longint'(refine_thr) * scale) any_above = 1'b1;
		if (!(lhs < longint'(derefine_thr) * scale)) all_below = 1'b0;
	endfunction

	// Append one expected decision word behind those already waiting
	function automatic void queue_decision(decision_t d);
		decisions_due = {decisions_due, d};
	endfunction

	// Advance the predictor by one accepted word; queue a decision at block end
	function automatic void tag_word(sample_t word_in);
		int unsigned     nx, ny, nz, lag;
		int              cx, cy, cz;
		bit              okx, oky, okz;
		longint          q;
		longint unsigned scale;

		nx = clamp_size(size_x_reg, 2, MAX_X);
		ny = clamp_size(size_y_reg, 1, MAX_Y);
		nz = clamp_size(size_z_reg, 1, MAX_Z);
		if (at_x >= nx || at_y >= ny || at_z >= nz) restart_block();

		// The centre under test trails the incoming word by its farthest neighbour
		cx = at_x;
		cy = at_y;
		cz = at_z;
		if (nz > 1) begin
			lag = nx * ny;
			cz--;
		end else if (ny > 1) begin
			lag = nx;
			cy--;
		end else begin
			lag = 1;
			cx--;
		end

		okx = cx >= 1 && cx <= int'(nx) - 2;
		oky = ny == 1 || (cy >= 1 && cy <= int'(ny) - 2);
		okz = nz == 1 || (cz >= 1 && cz <= int'(nz) - 2);
		if (okx && oky && okz) begin
			q     = hist_back(lag, word_in);
			scale = ((q < 0) ? -q : q) + 1;
			test_pair(hist_back(lag - 1, word_in), hist_back(lag + 1, word_in), scale);
			if (ny > 1)
				test_pair(hist_back(lag - nx, word_in), hist_back(lag + nx, word_in), scale);
			if (nz > 1)
				test_pair(hist_back(lag - nx * ny, word_in),
					hist_back(lag + nx * ny, word_in), scale);
		end

		plane_hist[hist_ptr] = word_in;
		hist_ptr = (hist_ptr + 1 >= RING_DEPTH) ? 0 : hist_ptr + 1;

		if (at_x + 1 == nx && at_y + 1 == ny && at_z + 1 == nz) begin
			// Refine wins over derefine; a zero derefine threshold never derefines
			if (any_above)
				queue_decision(DEC_REFINE);
			else if (all_below && derefine_thr != 0)
				queue_decision(DEC_DEREFINE);
			else
				queue_decision(DEC_KEEP);
			restart_block();
			return;
		end
		at_x++;
		if (at_x == nx) begin
			at_x = 0;
			at_y++;
			if (at_y == ny) begin
				at_y = 0;
				at_z++;
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// Offer one cell word, maybe after a short gap, and hold it until taken.
	// Valid stays high afterwards so back-to-back words need no re-raise.
	task automatic send_word(sample_t w);
		int unsigned gap;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			cells_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cells_ch.valid  <= 1'b1;
		cells_ch.sample <= w;
		@(posedge clk);
		while (cells_ch.ready !== 1'b1) @(posedge clk);
		tag_word(w);
		words_sent++;
	endtask

	// Drop valid, wait for every queued decision, then let the pipe empty
	task automatic drain();
		cells_ch.valid <= 1'b0;
		while (decisions_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hold the write enable across consecutive writes; reg_release drops it
	task automatic reg_write(logic [CFG_IDX_W-1:0] idx, thr_t data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		model_reg_write(idx, data);
	endtask

	task automatic reg_release();
		cfg_write <= 1'b0;
	endtask

	// Size registers only keep the low bits: fill the rest with noise
	function automatic thr_t size_word(int unsigned n);
		thr_t w;
		w = thr_t'($urandom);
		w[SIZE_W-1:0] = SIZE_W'(n);
		return w;
	endfunction

	task automatic program_block(thr_t refine, thr_t derefine,
			int unsigned sx, int unsigned sy, int unsigned sz);
		drain();
		reg_write(REG_REFINE_THR, refine);
		reg_write(REG_DEREFINE_THR, derefine);
		reg_write(REG_SIZE_X, size_word(sx));
		reg_write(REG_SIZE_Y, size_word(sy));
		reg_write(REG_SIZE_Z, size_word(sz));
		reg_release();
	endtask

	function automatic thr_t pick_threshold();
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return THR_MAX;
			2:       return thr_t'($urandom);
			3:       return thr_t'($urandom_range(0, 65536));
			default: return thr_t'($urandom_range(0, 8192));
		endcase
	endfunction

	// Send one block in raster order, or only its first part when truncate is set
	task automatic send_block(field_kind_t kind, bit truncate);
		int unsigned nx, ny, nz, total, cut, n;
		int          base, slope;
		sample_t     w;

		nx    = clamp_size(size_x_reg, 2, MAX_X);
		ny    = clamp_size(size_y_reg, 1, MAX_Y);
		nz    = clamp_size(size_z_reg, 1, MAX_Z);
		total = nx * ny * nz;
		cut   = truncate ? $urandom_range(1, total - 1) : total;
		base  = $urandom;
		slope = int'($urandom_range(0, 8191)) - 4096;
		if (kind == FIELD_SMOOTH) begin
			// Large magnitude with tiny ripple: relative gradients stay small
			base = $urandom_range(1 << 20, 1 << 28);
			if ($urandom_range(0, 1) == 1) base = -base;
		end
		n = 0;
		for (int unsigned z = 0; z < nz; z++)
			for (int unsigned y = 0; y < ny; y++)
				for (int unsigned x = 0; x < nx; x++) begin
					if (n == cut) return;
					case (kind)
						FIELD_NOISE:  w = $urandom;
						FIELD_FLAT:   w = base;
						FIELD_SMOOTH: w = base + int'($urandom_range(0, 64)) - 32;
						FIELD_RAMP:   w = base + int'(x) * slope + int'(y) * slope * 3
								+ int'(z) * slope * 7;
						default:      w = int'($urandom_range(0, 511)) - 256;
					endcase
					send_word(w);
					n++;
				end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Field extremes under the reset thresholds, the empty interior and the
	// refine-over-derefine priority, all on tiny 1D blocks
	task automatic test_corner_values();
		idle_on = 1'b1;
		drain();
		// Write sizes only: the thresholds keep their reset values
		reg_write(REG_SIZE_X, size_word(3));
		reg_write(REG_SIZE_Y, size_word(1));
		reg_write(REG_SIZE_Z, size_word(1));
		reg_release();

		send_word('0);
		send_word('0);
		send_word('0);
		// Widest possible difference around a zero centre
		send_word(SAMPLE_MIN);
		send_word('0);
		send_word(SAMPLE_MAX);
		// Most negative centre, equal neighbours
		send_word(SAMPLE_MAX);
		send_word(SAMPLE_MIN);
		send_word(SAMPLE_MAX);
		// Gradient between the two reset thresholds
		send_word(SAMPLE_ONE - KEEP_STEP);
		send_word(SAMPLE_ONE);
		send_word(SAMPLE_ONE + KEEP_STEP);

		// No interior cell: derefine, or keep when the derefine threshold is zero
		program_block(REFINE_THR_RST, DEREFINE_THR_RST, 2, 1, 1);
		send_word($urandom);
		send_word($urandom);
		program_block(REFINE_THR_RST, '0, 2, 1, 1);
		send_word($urandom);
		send_word($urandom);

		// Both flags hold at once: refine must win
		program_block('0, THR_MAX, 3, 1, 1);
		send_word(1);
		send_word(1);
		send_word(2);
		program_block(THR_MAX, '0, 3, 1, 1);
		send_word(SAMPLE_MIN);
		send_word('0);
		send_word(SAMPLE_MAX);
	endtask

	// Spare indexes leave a block running; a real write restarts it; sizes
	// below range saturate
	task automatic test_register_writes();
		idle_on = 1'b1;
		program_block(REFINE_THR_RST, DEREFINE_THR_RST, 3, 1, 1);
		send_word($urandom);
		drain();
		reg_write(REG_SPARE_FIRST, thr_t'($urandom));
		reg_write(REG_SPARE_LAST, thr_t'($urandom));
		reg_release();
		send_word($urandom);
		send_word($urandom);

		send_word($urandom);
		send_word($urandom);
		drain();
		reg_write(REG_SIZE_X, size_word(3));
		reg_release();
		send_block(FIELD_NOISE, 1'b0);

		program_block(pick_threshold(), pick_threshold(), 0, 0, 0);
		send_block(FIELD_NOISE, 1'b0);
		program_block(pick_threshold(), pick_threshold(), 4, 3, 1);
		send_block(FIELD_SMOOTH, 1'b0);
		program_block(pick_threshold(), pick_threshold(), 3, 3, 3);
		send_block(FIELD_RAMP, 1'b0);
	endtask

	// Widest row, written as 127 so it clamps to 64, on three rows so the row store
	// wraps at its full depth
	task automatic test_size_extremes();
		idle_on = 1'b1;
		program_block(pick_threshold(), pick_threshold(), 127, 3, 1);
		send_block(FIELD_RAMP, 1'b0);
	endtask

	// Random settings, mostly whole blocks back to back, now and then a
	// block cut short by the next set of register writes
	task automatic test_random_blocks();
		int unsigned start_words, start_decisions, blocks;
		start_words     = words_sent;
		start_decisions = decisions_seen;
		while (words_sent - start_words < RANDOM_WORDS
				|| decisions_seen - start_decisions < RANDOM_DECISIONS) begin
			idle_on = $urandom_range(0, 3) != 0;
			program_block(pick_threshold(), pick_threshold(),
				$urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 4));
			blocks = $urandom_range(1, 3);
			repeat (blocks) begin
				if ($urandom_range(0, 9) == 0) begin
					send_block(field_kind_t'($urandom_range(0, 4)), 1'b1);
					break;
				end
				send_block(field_kind_t'($urandom_range(0, 4)), 1'b0);
			end
		end
	endtask

	// Closing stretch at full rate on both sides
	task automatic test_steady_stream();
		idle_on = 1'b0;
		repeat (2) begin
			program_block(pick_threshold(), pick_threshold(),
				$urandom_range(2, 5), $urandom_range(1, 4), $urandom_range(1, 4));
			repeat (2) send_block(field_kind_t'($urandom_range(0, 4)), 1'b0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Decision sink: random stall bursts while idling is on
	// ------------------------------------------------------------------------
	initial begin
		int unsigned hold;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold != 0) begin
				result_ch.ready <= 1'b0;
				hold--;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				hold = $urandom_range(0, 3);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Checker: every decision word against the oldest queued one
	// ------------------------------------------------------------------------
	initial begin
		decision_t want;
		forever begin
			@(posedge clk);
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				decisions_seen++;
				if (decisions_due.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: decision %0d with none expected",
							$time, result_ch.decision);
				end else begin
					want = decisions_due.pop_front();
					if (result_ch.decision !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: decision expected %s (%0d), got %0d",
								$time, want.name(), want, result_ch.decision);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: too long without any handshake or register write ends the run
	// ------------------------------------------------------------------------
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((cells_ch.valid === 1'b1 && cells_ch.ready === 1'b1)
					|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
					|| cfg_write === 1'b1)
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		mismatches     = 0;
		words_sent     = 0;
		decisions_seen = 0;
		idle_on        = 1'b0;
		reset_model();

		arst_n          <= 1'b0;
		cfg_write       <= 1'b0;
		cfg_index       <= REG_REFINE_THR;
		cfg_data        <= '0;
		cells_ch.valid  <= 1'b0;
		cells_ch.sample <= '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_values();
		test_register_writes();
		test_size_extremes();
		test_random_blocks();
		test_steady_stream();

		// Wait out the last decisions and the pipe behind them
		drain();

		if (mismatches == 0 && decisions_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
